// ===== hw/rtl/hcu_pkg.sv =====
`default_nettype none
package hcu_pkg;

    localparam int HOUSE_COUNT_DEF = 16;
    localparam int UNIT_COUNT_DEF  = 16;

    localparam logic [2:0] OP_ADDRESS = 3'd0;
    localparam logic [2:0] OP_ON      = 3'd1;
    localparam logic [2:0] OP_OFF     = 3'd2;
    localparam logic [2:0] OP_ALL_ON  = 3'd3;
    localparam logic [2:0] OP_ALL_OFF = 3'd4;
    localparam logic [2:0] OP_EXT_DIM = 3'd5;
    localparam logic [2:0] OP_QUERY   = 3'd6;

    localparam logic [1:0] ST_UNKNOWN = 2'd0;
    localparam logic [1:0] ST_OFF     = 2'd1;
    localparam logic [1:0] ST_ON      = 2'd2;

    localparam logic [7:0] FULL_ON_DIM = 8'd63;
    localparam logic [7:0] ZERO_DIM    = 8'd0;

    typedef struct packed {
        logic [2:0] op;
        logic [3:0] house;
        logic [3:0] unit;
        logic [7:0] level;
    } hcu_req_t;

    typedef struct packed {
        logic [1:0] unit_status;
        logic [7:0] unit_dim;
        logic       unit_selected;
    } hcu_rsp_t;

    // One unit's entry inside a house row.
    typedef struct packed {
        logic [1:0] status;
        logic [7:0] dim;
        logic       sel;
    } hcu_lane_t;

    typedef enum logic {
        S_IDLE,
        S_READ
    } hcu_state_t;

endpackage
`default_nettype wire

// ===== hw/rtl/home_control_unit_state_tracker_core.sv =====
`default_nettype none
// The item is registered and its house row read from the RAM when the item is taken;
// the result register loads once the output register is empty or its result is being
// taken, and the result is offered from then on. One item is worked on at a time: the
// input stalls until the result is registered, as the house row is written back.
// Reset: asynchronous, active low. All row valid bits and function flags clear at
// once, so every unit reads as unknown, dim zero and unselected; no clearing pass.
module home_control_unit_state_tracker_core #(
    parameter int HOUSE_COUNT = hcu_pkg::HOUSE_COUNT_DEF,
    parameter int UNIT_COUNT  = hcu_pkg::UNIT_COUNT_DEF
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              req_valid,
    output logic                   req_stall,
    input  wire hcu_pkg::hcu_req_t req,
    output logic                   rsp_valid,
    input  wire logic              rsp_stall,
    output hcu_pkg::hcu_rsp_t      rsp
);

    localparam int HOUSE_AW = (HOUSE_COUNT > 1) ? $clog2(HOUSE_COUNT) : 1;
    localparam int ROW_W    = UNIT_COUNT * $bits(hcu_pkg::hcu_lane_t);

    hcu_pkg::hcu_state_t state_reg, state_next;
    hcu_pkg::hcu_req_t   item_reg;
    logic                house_ok_reg;
    logic                out_valid_reg, out_valid_next;
    hcu_pkg::hcu_rsp_t   rsp_reg;
    logic [HOUSE_COUNT-1:0] row_valid_reg, row_valid_next;
    logic [HOUSE_COUNT-1:0] fseen_reg, fseen_next;

    logic                accept;
    logic                finish;
    logic                we;
    logic [HOUSE_AW-1:0] haddr;
    logic [ROW_W-1:0]    rd_data;
    logic [ROW_W-1:0]    row_cur;
    logic [ROW_W-1:0]    row_new;
    logic                fseen_cur;
    logic                fseen_new;
    hcu_pkg::hcu_rsp_t   upd_rsp;

    assign accept    = req_valid && !req_stall;
    assign haddr     = item_reg.house[HOUSE_AW-1:0];
    assign finish    = (state_reg == hcu_pkg::S_READ) && (!out_valid_reg || !rsp_stall);
    assign we        = finish && house_ok_reg;
    assign rsp_valid = out_valid_reg;
    assign rsp       = rsp_reg;

    hcu_ram #(
        .WIDTH(ROW_W),
        .DEPTH(HOUSE_COUNT)
    ) u_row_ram (
        .clk  (clk),
        .we   (we),
        .waddr(haddr),
        .wdata(row_new),
        .re   (accept),
        .raddr(req.house[HOUSE_AW-1:0]),
        .rdata(rd_data)
    );

    // A row never written since reset reads as all zero.
    always_comb
    begin
        row_cur   = '0;
        fseen_cur = 1'b0;
        if (house_ok_reg)
        begin
            if (row_valid_reg[haddr])
            begin
                row_cur = rd_data;
            end
            fseen_cur = fseen_reg[haddr];
        end
    end

    hcu_row_update #(
        .UNIT_COUNT(UNIT_COUNT)
    ) u_update (
        .item     (item_reg),
        .row_in   (row_cur),
        .fseen_in (fseen_cur),
        .row_out  (row_new),
        .fseen_out(fseen_new),
        .rsp      (upd_rsp)
    );

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg;
        row_valid_next = row_valid_reg;
        fseen_next     = fseen_reg;
        req_stall      = (state_reg != hcu_pkg::S_IDLE);
        if (out_valid_reg && !rsp_stall)
        begin
            out_valid_next = 1'b0;
        end
        case (state_reg)
            hcu_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    state_next = hcu_pkg::S_READ;
                end
            end
            hcu_pkg::S_READ:
            begin
                if (finish)
                begin
                    state_next     = hcu_pkg::S_IDLE;
                    out_valid_next = 1'b1;
                end
                if (we)
                begin
                    row_valid_next[haddr] = 1'b1;
                    fseen_next[haddr]     = fseen_new;
                end
            end
            default:
            begin
                state_next = hcu_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= hcu_pkg::S_IDLE;
            out_valid_reg <= 1'b0;
            row_valid_reg <= '0;
            fseen_reg     <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            row_valid_reg <= row_valid_next;
            fseen_reg     <= fseen_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg     <= req;
            house_ok_reg <= {1'b0, req.house} < 5'(HOUSE_COUNT);
        end
        if (finish)
        begin
            rsp_reg <= house_ok_reg ? upd_rsp : '0;
        end
    end

endmodule
`default_nettype wire

// ===== hw/rtl/hcu_ram.sv =====
`default_nettype none
module hcu_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                                  clk,
    input  wire logic                                  we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                      wdata,
    input  wire logic                                  re,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]                      rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule
`default_nettype wire

// ===== hw/rtl/hcu_row_update.sv =====
`default_nettype none
module hcu_row_update #(
    parameter int UNIT_COUNT = hcu_pkg::UNIT_COUNT_DEF
) (
    input  wire hcu_pkg::hcu_req_t                               item,
    input  wire logic [UNIT_COUNT*$bits(hcu_pkg::hcu_lane_t)-1:0] row_in,
    input  wire logic                                            fseen_in,
    output logic      [UNIT_COUNT*$bits(hcu_pkg::hcu_lane_t)-1:0] row_out,
    output logic                                                 fseen_out,
    output hcu_pkg::hcu_rsp_t                                    rsp
);

    localparam int UNIT_AW = (UNIT_COUNT > 1) ? $clog2(UNIT_COUNT) : 1;

    hcu_pkg::hcu_lane_t [UNIT_COUNT-1:0] lanes_in;
    hcu_pkg::hcu_lane_t [UNIT_COUNT-1:0] lanes_out;
    hcu_pkg::hcu_lane_t                  named;
    logic                                unit_ok;
    logic [UNIT_AW-1:0]                  uidx;

    assign lanes_in = row_in;
    assign row_out  = lanes_out;
    assign unit_ok  = {1'b0, item.unit} < 5'(UNIT_COUNT);
    assign uidx     = item.unit[UNIT_AW-1:0];

    always_comb
    begin
        lanes_out = lanes_in;
        fseen_out = fseen_in;
        case (item.op)
            hcu_pkg::OP_ADDRESS:
            begin
                if (unit_ok)
                begin
                    // A function since the last address starts a new selection.
                    fseen_out = 1'b0;
                    for (int u = 0; u < UNIT_COUNT; u++)
                    begin
                        lanes_out[u].sel = (lanes_in[u].sel && !fseen_in)
                                           || ({1'b0, item.unit} == 5'(u));
                    end
                end
            end
            hcu_pkg::OP_ON, hcu_pkg::OP_OFF, hcu_pkg::OP_EXT_DIM:
            begin
                fseen_out = 1'b1;
                for (int u = 0; u < UNIT_COUNT; u++)
                begin
                    if (lanes_in[u].sel)
                    begin
                        if (item.op == hcu_pkg::OP_ON)
                        begin
                            lanes_out[u].status = hcu_pkg::ST_ON;
                            lanes_out[u].dim    = hcu_pkg::FULL_ON_DIM;
                        end
                        else if (item.op == hcu_pkg::OP_OFF)
                        begin
                            lanes_out[u].status = hcu_pkg::ST_OFF;
                            lanes_out[u].dim    = hcu_pkg::ZERO_DIM;
                        end
                        else
                        begin
                            lanes_out[u].status = (item.level != hcu_pkg::ZERO_DIM)
                                                  ? hcu_pkg::ST_ON : hcu_pkg::ST_OFF;
                            lanes_out[u].dim    = item.level;
                        end
                    end
                end
            end
            hcu_pkg::OP_ALL_ON, hcu_pkg::OP_ALL_OFF:
            begin
                fseen_out = 1'b1;
                for (int u = 0; u < UNIT_COUNT; u++)
                begin
                    lanes_out[u].status = (item.op == hcu_pkg::OP_ALL_ON)
                                          ? hcu_pkg::ST_ON : hcu_pkg::ST_OFF;
                end
            end
            default:
            begin
                // Query and the unused code leave the row untouched.
            end
        endcase
    end

    always_comb
    begin
        named = '0;
        if (unit_ok)
        begin
            named = lanes_out[uidx];
        end
        rsp.unit_status   = named.status;
        rsp.unit_dim      = named.dim;
        rsp.unit_selected = named.sel;
    end

endmodule
`default_nettype wire

// ===== hw/rtl/hcu_checker.sv =====
`default_nettype none
module hcu_checker (
    input wire logic              clk,
    input wire logic              rst_n,
    input wire logic              req_valid,
    input wire logic              req_stall,
    input wire logic              rsp_valid,
    input wire logic              rsp_stall,
    input wire hcu_pkg::hcu_rsp_t rsp
);

    // A held result must not change while the receiver stalls.
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
        else $error("result changed or vanished under stall");

    // Only one item is worked on at a time.
    a_busy_after_transfer: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && !req_stall |=> req_stall)
        else $error("input taken while an item is in flight");

    // With the output free, a taken item goes through the READ state into an offered result.
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && !req_stall && !rsp_valid |-> ##2 rsp_valid)
        else $error("result late");

    // A new result only appears after the input side was held off.
    a_rsp_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid) |-> $past(req_stall))
        else $error("result without an item in flight");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> rsp.unit_status <= hcu_pkg::ST_ON)
        else $error("invalid unit status code");

endmodule

bind home_control_unit_state_tracker_core hcu_checker u_hcu_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .req_valid(req_valid),
    .req_stall(req_stall),
    .rsp_valid(rsp_valid),
    .rsp_stall(rsp_stall),
    .rsp      (rsp)
);
`default_nettype wire

// ===== dv/home_control_unit_state_tracker_core_tb.sv =====
module home_control_unit_state_tracker_core_tb;

    localparam int HOUSE_N = hcu_pkg::HOUSE_COUNT_DEF;
    localparam int UNIT_N = hcu_pkg::UNIT_COUNT_DEF;
    localparam logic [2:0] OP_SPARE = 3'd7;
    localparam int RANDOM_TARGET = 750;
    localparam int QUIET_FROM = 300;
    localparam int QUIET_TO = 420;
    localparam int HOLD_AT = 550;
    localparam int HOLD_LEN = 48;
    localparam int DRAIN_CYCLES = 12;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic req_valid = 1'b0;
    logic req_stall;
    hcu_pkg::hcu_req_t req = '0;
    logic rsp_valid;
    logic rsp_stall = 1'b0;
    hcu_pkg::hcu_rsp_t rsp;

    // Shadow copy of the tracker state, indexed [house][unit].
    logic [1:0] unit_status_mem [HOUSE_N][UNIT_N];
    logic [7:0] unit_dim_mem [HOUSE_N][UNIT_N];
    logic unit_sel_mem [HOUSE_N][UNIT_N];
    logic house_func_mode [HOUSE_N];

    hcu_pkg::hcu_req_t command_q[$];
    hcu_pkg::hcu_rsp_t status_due[$];
    hcu_pkg::hcu_rsp_t status_want;
    int mismatch_count = 0;
    int sent_count = 0;
    int rx_count = 0;
    int hold_left = 0;
    logic hold_done = 1'b0;

    home_control_unit_state_tracker_core dut (
        .clk(clk),
        .rst_n(rst_n),
        .req_valid(req_valid),
        .req_stall(req_stall),
        .req(req),
        .rsp_valid(rsp_valid),
        .rsp_stall(rsp_stall),
        .rsp(rsp)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic void set_selected_units(input int h, input logic [1:0] st,
                                               input logic [7:0] lvl);
        int u;
        for (u = 0; u < UNIT_N; u++)
        begin
            if (unit_sel_mem[h][u])
            begin
                unit_status_mem[h][u] = st;
                unit_dim_mem[h][u] = lvl;
            end
        end
    endfunction

    function automatic void set_whole_house(input int h, input logic [1:0] st);
        int u;
        for (u = 0; u < UNIT_N; u++)
            unit_status_mem[h][u] = st;
    endfunction

    // Applies one command to the shadow state and returns the named unit's status.
    function automatic hcu_pkg::hcu_rsp_t track_unit(input hcu_pkg::hcu_req_t c);
        hcu_pkg::hcu_rsp_t res;
        int h;
        int u;
        logic house_ok;
        logic unit_ok;
        res = '0;
        h = int'(c.house);
        u = int'(c.unit);
        house_ok = (h < HOUSE_N);
        unit_ok = (u < UNIT_N);
        if (house_ok)
        begin
            case (c.op)
                hcu_pkg::OP_ADDRESS:
                begin
                    if (unit_ok)
                    begin
                        // A new address after a function starts a fresh selection.
                        if (house_func_mode[h])
                        begin
                            for (int k = 0; k < UNIT_N; k++)
                                unit_sel_mem[h][k] = 1'b0;
                            house_func_mode[h] = 1'b0;
                        end
                        unit_sel_mem[h][u] = 1'b1;
                    end
                end
                hcu_pkg::OP_ON:
                begin
                    house_func_mode[h] = 1'b1;
                    set_selected_units(h, hcu_pkg::ST_ON, hcu_pkg::FULL_ON_DIM);
                end
                hcu_pkg::OP_OFF:
                begin
                    house_func_mode[h] = 1'b1;
                    set_selected_units(h, hcu_pkg::ST_OFF, hcu_pkg::ZERO_DIM);
                end
                hcu_pkg::OP_ALL_ON:
                begin
                    house_func_mode[h] = 1'b1;
                    set_whole_house(h, hcu_pkg::ST_ON);
                end
                hcu_pkg::OP_ALL_OFF:
                begin
                    house_func_mode[h] = 1'b1;
                    set_whole_house(h, hcu_pkg::ST_OFF);
                end
                hcu_pkg::OP_EXT_DIM:
                begin
                    house_func_mode[h] = 1'b1;
                    set_selected_units(h, (c.level != 8'd0) ? hcu_pkg::ST_ON
                                                            : hcu_pkg::ST_OFF, c.level);
                end
                default:
                begin
                end
            endcase
        end
        if (house_ok && unit_ok)
        begin
            res.unit_status = unit_status_mem[h][u];
            res.unit_dim = unit_dim_mem[h][u];
            res.unit_selected = unit_sel_mem[h][u];
        end
        return res;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("mismatch at result %0d: %s got %0d expected %0d", rx_count, what, got, want);
        mismatch_count++;
    endtask

    task automatic add_command(input logic [2:0] op, input int house, input int unit,
                               input int level);
        hcu_pkg::hcu_req_t c;
        c.op = op;
        c.house = house[3:0];
        c.unit = unit[3:0];
        c.level = level[7:0];
        command_q.push_back(c);
    endtask

    // Driver: a transfer is taken at an edge where valid is high and stall is low.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_valid <= 1'b0;
            req <= '0;
        end
        else
        begin
            if (req_valid && !req_stall)
            begin
                status_due.push_back(track_unit(req));
                sent_count <= sent_count + 1;
            end
            if (!req_valid || !req_stall)
            begin
                if (command_q.size() > 0 &&
                    ((sent_count >= QUIET_FROM && sent_count < QUIET_TO) ||
                     $urandom_range(99) >= 11))
                begin
                    req <= command_q.pop_front();
                    req_valid <= 1'b1;
                end
                else
                    req_valid <= 1'b0;
            end
        end
    end

    // One long hold-off on the result side, so that the block backs up into its input.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_left <= 0;
            hold_done <= 1'b0;
        end
        else if (!hold_done && rx_count >= HOLD_AT)
        begin
            hold_left <= HOLD_LEN;
            hold_done <= 1'b1;
        end
        else if (hold_left != 0)
            hold_left <= hold_left - 1;
    end

    // Monitor: checks each result transfer against the oldest expected status.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_stall <= 1'b0;
            rx_count <= 0;
        end
        else
        begin
            if (rsp_valid && !rsp_stall)
            begin
                rx_count <= rx_count + 1;
                if (status_due.size() == 0)
                    report_mismatch("result with nothing outstanding", int'(rsp), 0);
                else
                begin
                    status_want = status_due.pop_front();
                    if (rsp.unit_status !== status_want.unit_status)
                        report_mismatch("unit_status", int'(rsp.unit_status),
                                        int'(status_want.unit_status));
                    if (rsp.unit_dim !== status_want.unit_dim)
                        report_mismatch("unit_dim", int'(rsp.unit_dim),
                                        int'(status_want.unit_dim));
                    if (rsp.unit_selected !== status_want.unit_selected)
                        report_mismatch("unit_selected", int'(rsp.unit_selected),
                                        int'(status_want.unit_selected));
                end
            end
            rsp_stall <= (hold_left != 0) ||
                         (!(rx_count >= QUIET_FROM && rx_count < QUIET_TO) &&
                          $urandom_range(99) < 11);
        end
    end

    initial
    begin
        #2000000;
        $display("FAILURE");
        $finish;
    end

    initial
    begin
        int house;
        int n;
        int level;
        int random_start;
        logic [2:0] fn;

        for (int h = 0; h < HOUSE_N; h++)
        begin
            house_func_mode[h] = 1'b0;
            for (int u = 0; u < UNIT_N; u++)
            begin
                unit_status_mem[h][u] = hcu_pkg::ST_UNKNOWN;
                unit_dim_mem[h][u] = hcu_pkg::ZERO_DIM;
                unit_sel_mem[h][u] = 1'b0;
            end
        end

        // Directed part.
        add_command(hcu_pkg::OP_QUERY, 0, 0, 0);      // everything unknown after reset
        add_command(hcu_pkg::OP_ADDRESS, 0, 3, 255);
        add_command(hcu_pkg::OP_ADDRESS, 0, 15, 0);   // selection accumulates while addressing
        add_command(hcu_pkg::OP_ON, 0, 3, 255);       // level is ignored by on
        add_command(hcu_pkg::OP_QUERY, 0, 15, 0);
        add_command(hcu_pkg::OP_EXT_DIM, 0, 3, 255);
        add_command(hcu_pkg::OP_EXT_DIM, 0, 15, 0);   // zero level turns the units off
        add_command(hcu_pkg::OP_EXT_DIM, 0, 3, 1);
        add_command(hcu_pkg::OP_ADDRESS, 0, 5, 128);  // address after a function clears selection
        add_command(hcu_pkg::OP_QUERY, 0, 3, 0);
        add_command(hcu_pkg::OP_OFF, 0, 5, 0);
        add_command(hcu_pkg::OP_ON, 1, 0, 0);         // function with nothing selected
        add_command(hcu_pkg::OP_ADDRESS, 1, 0, 0);
        add_command(hcu_pkg::OP_QUERY, 1, 0, 0);
        add_command(hcu_pkg::OP_ALL_ON, 15, 15, 0);
        add_command(hcu_pkg::OP_QUERY, 15, 0, 0);
        add_command(hcu_pkg::OP_ALL_OFF, 15, 0, 255);
        add_command(hcu_pkg::OP_ADDRESS, 15, 15, 0);
        add_command(hcu_pkg::OP_EXT_DIM, 15, 15, 128);
        add_command(hcu_pkg::OP_ALL_ON, 15, 15, 0);   // dim survives all on and all off
        add_command(OP_SPARE, 0, 3, 255);             // spare op code behaves as a query
        add_command(OP_SPARE, 15, 15, 0);
        add_command(hcu_pkg::OP_ADDRESS, 0, 3, 0);
        add_command(hcu_pkg::OP_QUERY, 0, 5, 0);
        random_start = command_q.size();

        // Random part: mostly address-then-function sequences, some noise.
        while (command_q.size() < random_start + RANDOM_TARGET)
        begin
            if ($urandom_range(99) < 20)
                add_command(3'($urandom_range(7)), $urandom_range(15), $urandom_range(15),
                            $urandom_range(255));
            else
            begin
                house = $urandom_range(1) ? $urandom_range(3) : $urandom_range(15);
                n = $urandom_range(1, 3);
                repeat (n)
                    add_command(hcu_pkg::OP_ADDRESS, house, $urandom_range(15),
                                $urandom_range(255));
                n = $urandom_range(1, 3);
                repeat (n)
                begin
                    case ($urandom_range(4))
                        0: fn = hcu_pkg::OP_ON;
                        1: fn = hcu_pkg::OP_OFF;
                        2: fn = hcu_pkg::OP_ALL_ON;
                        3: fn = hcu_pkg::OP_ALL_OFF;
                        default: fn = hcu_pkg::OP_EXT_DIM;
                    endcase
                    level = ($urandom_range(3) == 0) ? 0 : $urandom_range(255);
                    add_command(fn, house, $urandom_range(15), level);
                end
                if ($urandom_range(3) == 0)
                    add_command(hcu_pkg::OP_QUERY, house, $urandom_range(15),
                                $urandom_range(255));
            end
        end

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        do
            @(negedge clk);
        while (command_q.size() != 0 || req_valid || status_due.size() != 0);
        repeat (DRAIN_CYCLES) @(negedge clk);

        if (mismatch_count == 0 && status_due.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

// ===== files.f =====
hw/rtl/hcu_pkg.sv
hw/rtl/hcu_ram.sv
hw/rtl/hcu_row_update.sv
hw/rtl/home_control_unit_state_tracker_core.sv
hw/rtl/hcu_checker.sv
dv/home_control_unit_state_tracker_core_tb.sv
